// ===== rtl/assert_macros.svh =====
// assertion macros included by point_in_polygon_with_holes_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk and off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pip_holes_pkg.sv =====
// types and constants of the point in polygon with holes locator
package pip_holes_pkg;

    localparam int FIELD_BITS = 32;

    localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
    localparam logic [1:0] LOC_INSIDE   = 2'd1;
    localparam logic [1:0] LOC_BOUNDARY = 2'd2;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] query_x;
        logic signed [FIELD_BITS-1:0] query_y;
        logic signed [FIELD_BITS-1:0] edge_start_x;
        logic signed [FIELD_BITS-1:0] edge_start_y;
        logic signed [FIELD_BITS-1:0] edge_end_x;
        logic signed [FIELD_BITS-1:0] edge_end_y;
        logic                         ring_is_hole;
        logic                         last_of_ring;
        logic                         last_of_domain;
    } edge_item_t;

    typedef struct packed {
        logic [1:0] ring_location;
        logic       strictly_inside;
        logic       domain_done;
    } result_item_t;

endpackage

// ===== rtl/point_in_polygon_with_holes_top.sv =====
// point in polygon with holes locator, crossing number over streamed edges
//
// usage: send one ring edge per item on the edge channel, each carrying the
// query point, the edge end points, the hole flag and the ring and domain
// end marks. edges of a ring arrive in order; the closing edge has
// last_of_ring set, and the closing edge of the final ring also has
// last_of_domain set. one result item leaves on the result channel for each
// closing edge: ring location (outside, inside, boundary), the domain
// verdict so far and a domain done flag.
// the closing edge passes the input register, the product register and the
// result register before its result item is valid. throughput: one edge per
// cycle while no result waits under result_stall; the two 33x33 products of
// the orientation test set the middle stage.
// reset clears all valid bits, parity and boundary flags, and sets the
// domain verdict to inside.
// while a result waits under result_stall the whole pipeline holds and
// edge_stall is raised; otherwise edges are taken every cycle.
module point_in_polygon_with_holes_top #(
    parameter int COORD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        edge_valid,
    output logic                        edge_stall,
    input  pip_holes_pkg::edge_item_t   edge_item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output pip_holes_pkg::result_item_t result_item
);

    `include "assert_macros.svh"

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    typedef struct packed {
        logic signed [PW-1:0] prod_r;
        logic signed [PW-1:0] prod_l;
        logic                 in_box;
        logic                 a_above;
        logic                 b_above;
        logic                 upward;
        logic                 ring_is_hole;
        logic                 last_of_ring;
        logic                 last_of_domain;
    } prod_stage_t;

    logic                        advance;
    logic                        s1_valid_reg;
    pip_holes_pkg::edge_item_t   s1_reg;
    logic                        s2_valid_reg;
    prod_stage_t                 s2_reg;
    prod_stage_t                 s2_next;
    logic                        out_valid_reg;
    pip_holes_pkg::result_item_t out_reg;
    pip_holes_pkg::result_item_t out_next;
    logic                        parity_reg;
    logic                        parity_next;
    logic                        boundary_reg;
    logic                        boundary_next;
    logic                        verdict_reg;
    logic                        verdict_next;

    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [DW-1:0]         dx_ab;
    logic signed [DW-1:0]         dy_pa;
    logic signed [DW-1:0]         dy_ab;
    logic signed [DW-1:0]         dx_pa;

    logic       orient_pos;
    logic       orient_neg;
    logic       on_seg;
    logic       crosses;
    logic       ring_parity;
    logic       ring_boundary;
    logic [1:0] loc;
    logic       ring_verdict;

    assign advance    = !out_valid_reg || !result_stall;
    assign edge_stall = !advance;

    // stage 2: differences, products and cheap coordinate compares
    always_comb
    begin
        px = s1_reg.query_x[COORD_BITS-1:0];
        py = s1_reg.query_y[COORD_BITS-1:0];
        ax = s1_reg.edge_start_x[COORD_BITS-1:0];
        ay = s1_reg.edge_start_y[COORD_BITS-1:0];
        bx = s1_reg.edge_end_x[COORD_BITS-1:0];
        by = s1_reg.edge_end_y[COORD_BITS-1:0];
        dx_ab = DW'(bx) - DW'(ax);
        dy_pa = DW'(py) - DW'(ay);
        dy_ab = DW'(by) - DW'(ay);
        dx_pa = DW'(px) - DW'(ax);
        s2_next.prod_r = PW'(dx_ab) * PW'(dy_pa);
        s2_next.prod_l = PW'(dy_ab) * PW'(dx_pa);
        s2_next.in_box = (px >= ax || px >= bx) && (px <= ax || px <= bx)
                      && (py >= ay || py >= by) && (py <= ay || py <= by);
        s2_next.a_above        = ay > py;
        s2_next.b_above        = by > py;
        s2_next.upward         = by > ay;
        s2_next.ring_is_hole   = s1_reg.ring_is_hole;
        s2_next.last_of_ring   = s1_reg.last_of_ring;
        s2_next.last_of_domain = s1_reg.last_of_domain;
    end

    // stage 3: orientation sign, ring state and result
    always_comb
    begin
        orient_pos = s2_reg.prod_r > s2_reg.prod_l;
        orient_neg = s2_reg.prod_r < s2_reg.prod_l;
        on_seg     = !orient_pos && !orient_neg && s2_reg.in_box;
        crosses    = !on_seg && (s2_reg.a_above != s2_reg.b_above)
                  && ((s2_reg.upward && orient_pos) || (!s2_reg.upward && orient_neg));
        ring_boundary = boundary_reg || on_seg;
        ring_parity   = parity_reg ^ (crosses && !boundary_reg);
        if (ring_boundary)
        begin
            loc = pip_holes_pkg::LOC_BOUNDARY;
        end
        else if (ring_parity)
        begin
            loc = pip_holes_pkg::LOC_INSIDE;
        end
        else
        begin
            loc = pip_holes_pkg::LOC_OUTSIDE;
        end
        if (s2_reg.ring_is_hole)
        begin
            ring_verdict = verdict_reg && (loc == pip_holes_pkg::LOC_OUTSIDE);
        end
        else
        begin
            ring_verdict = verdict_reg && (loc == pip_holes_pkg::LOC_INSIDE);
        end
        out_next.ring_location   = loc;
        out_next.strictly_inside = ring_verdict;
        out_next.domain_done     = s2_reg.last_of_domain;

        parity_next   = parity_reg;
        boundary_next = boundary_reg;
        verdict_next  = verdict_reg;
        if (s2_valid_reg)
        begin
            if (s2_reg.last_of_ring)
            begin
                parity_next   = 1'b0;
                boundary_next = 1'b0;
                verdict_next  = s2_reg.last_of_domain || ring_verdict;
            end
            else
            begin
                parity_next   = ring_parity;
                boundary_next = ring_boundary;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            parity_reg    <= 1'b0;
            boundary_reg  <= 1'b0;
            verdict_reg   <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg  <= edge_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_reg.last_of_ring;
            parity_reg    <= parity_next;
            boundary_reg  <= boundary_next;
            verdict_reg   <= verdict_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg  <= edge_item;
            s2_reg  <= s2_next;
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    `ASSERT_NEXT(a_result_from_ring_end,
        !(advance && s2_valid_reg && s2_reg.last_of_ring), !out_valid_reg || !$past(advance),
        "result raised without a closing edge")
    `ASSERT_NEXT(a_ring_state_cleared, advance && s2_valid_reg && s2_reg.last_of_ring,
        !parity_reg && !boundary_reg, "ring state not cleared after closing edge")
    `ASSERT_NEXT(a_verdict_restored,
        advance && s2_valid_reg && s2_reg.last_of_ring && s2_reg.last_of_domain,
        verdict_reg, "domain verdict not restored after domain end")
    `ASSERT_IMPL(a_location_code, out_valid_reg,
        out_reg.ring_location == pip_holes_pkg::LOC_OUTSIDE
        || out_reg.ring_location == pip_holes_pkg::LOC_INSIDE
        || out_reg.ring_location == pip_holes_pkg::LOC_BOUNDARY,
        "unknown ring location code")
    `ASSERT_IMPL(a_boundary_excludes,
        out_valid_reg && out_reg.ring_location == pip_holes_pkg::LOC_BOUNDARY,
        !out_reg.strictly_inside, "boundary ring left verdict inside")

endmodule
